### hw/rtl/modular_exponentiation_unit_defines.svh
// assertion macros for the modular exponentiation unit
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// same-cycle implication
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mexp assertion failed");

// next-cycle implication
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mexp assertion failed");

`endif

### hw/rtl/mexp_pkg.sv
`default_nettype none
package mexp_pkg;

	localparam int DEFAULT_WORD_BITS = 32;
	localparam int CFG_INDEX_BITS    = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_MODULUS  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_EXPONENT = CFG_INDEX_BITS'(1);

	typedef enum logic [1:0] {
		OP_REDUCE = 2'd0,
		OP_MULT   = 2'd1,
		OP_SQUARE = 2'd2
	} op_t;

	typedef struct packed {
		logic load;
		logic start;
		op_t  op;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_odd;
		logic cnt_last;
		logic key_exp_zero;
		logic key_mod_zero;
	} sts_t;

endpackage
`default_nettype wire

### hw/rtl/modular_exponentiation_unit.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready   | cipher_word
// out     | output    | out_valid / out_ready | plain_word
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one shared shift-add modular multiplier, one operand bit per cycle; a word takes a
// reduction of the input word plus k multiplies and squarings, k the number of them
// that the exponent needs (up to 2 * WORD_BITS - 1)
// zero exponent or zero modulus: no multiplies, the word goes straight to the done state
// reset clears the fsm, the output valid flag, modulus to 1 and exponent to 0
// a new word is taken while the previous result waits in the output register
`default_nettype none
module modular_exponentiation_unit #(
	parameter int WORD_BITS = mexp_pkg::DEFAULT_WORD_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [WORD_BITS-1:0]                cipher_word,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [WORD_BITS-1:0]                     plain_word,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [WORD_BITS-1:0]                cfg_data
);
	import mexp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mexp_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cipher_word (cipher_word),
		.cmd         (cmd),
		.sts         (sts),
		.plain_word  (plain_word)
	);

endmodule
`default_nettype wire

### hw/rtl/mexp_datapath.sv
`default_nettype none
module mexp_datapath #(
	parameter int WORD_BITS = mexp_pkg::DEFAULT_WORD_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [WORD_BITS-1:0]                cfg_data,
	input  wire logic [WORD_BITS-1:0]                cipher_word,
	input  wire mexp_pkg::cmd_t                      cmd,
	output mexp_pkg::sts_t                           sts,
	output logic [WORD_BITS-1:0]                     plain_word
);
	import mexp_pkg::*;

	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

	logic [WORD_BITS-1:0] key_modulus_q;
	logic [WORD_BITS-1:0] key_exponent_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] res_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] opa_q;
	logic [WORD_BITS-1:0] opb_q;
	logic [WORD_BITS-1:0] plain_word_q;
	logic [CNT_BITS-1:0]  cnt_q;
	op_t                  op_q;

	logic [WORD_BITS-1:0] addend;
	logic [WORD_BITS+1:0] sum;
	logic [WORD_BITS+2:0] diff1;
	logic [WORD_BITS+2:0] diff2;
	logic [WORD_BITS-1:0] acc_next;
	logic                 cnt_last;
	logic                 mod_le_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_modulus_q  <= ONE;
			key_exponent_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_MODULUS) begin
				key_modulus_q <= cfg_data;
			end else if (cfg_index == REG_KEY_EXPONENT) begin
				key_exponent_q <= cfg_data;
			end
		end
	end

	// shift-add modular multiply step, sum stays below three times the modulus
	always_comb begin
		addend   = opb_q[WORD_BITS-1] ? opa_q : '0;
		sum      = {1'b0, acc_q, 1'b0} + {2'b00, addend};
		diff1    = {1'b0, sum} - {3'b000, key_modulus_q};
		diff2    = {1'b0, sum} - {2'b00, key_modulus_q, 1'b0};
		if (!diff2[WORD_BITS+2]) begin
			acc_next = diff2[WORD_BITS-1:0];
		end else if (!diff1[WORD_BITS+2]) begin
			acc_next = diff1[WORD_BITS-1:0];
		end else begin
			acc_next = sum[WORD_BITS-1:0];
		end
	end

	assign cnt_last   = cnt_q == CNT_BITS'(WORD_BITS - 1);
	assign mod_le_one = key_modulus_q <= ONE;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= cipher_word;
			exp_q  <= key_exponent_q;
			res_q  <= (key_exponent_q == '0) ? ONE : (mod_le_one ? '0 : ONE);
			op_q   <= OP_REDUCE;
			opa_q  <= ONE;
			opb_q  <= cipher_word;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			op_q  <= cmd.op;
			opa_q <= (cmd.op == OP_MULT) ? res_q : base_q;
			opb_q <= base_q;
			acc_q <= '0;
			cnt_q <= '0;
			if (cmd.op == OP_MULT) begin
				exp_q <= exp_q - ONE;
			end else begin
				exp_q <= exp_q >> 1;
			end
		end else if (cmd.step) begin
			acc_q <= acc_next;
			opb_q <= opb_q << 1;
			cnt_q <= cnt_q + CNT_BITS'(1);
			if (cnt_last) begin
				case (op_q)
					OP_MULT: res_q <= acc_next;
					default: base_q <= acc_next;
				endcase
			end
		end
		if (cmd.emit) begin
			plain_word_q <= res_q;
		end
	end

	assign sts.exp_zero     = exp_q == '0;
	assign sts.exp_odd      = exp_q[0];
	assign sts.cnt_last     = cnt_last;
	assign sts.key_exp_zero = key_exponent_q == '0;
	assign sts.key_mod_zero = key_modulus_q == '0;
	assign plain_word       = plain_word_q;

endmodule
`default_nettype wire

### hw/rtl/mexp_ctrl.sv
`default_nettype none
`include "modular_exponentiation_unit_defines.svh"
module mexp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire mexp_pkg::sts_t sts,
	output mexp_pkg::cmd_t      cmd
);
	import mexp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RUN    = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.op    = OP_REDUCE;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (sts.key_exp_zero || sts.key_mod_zero) ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.exp_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.start = 1'b1;
					cmd.op    = sts.exp_odd ? OP_MULT : OP_SQUARE;
					state_d   = ST_RUN;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`MEXP_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`MEXP_ASSERT_NXT(a_run_to_decide, clk, arst_n, state_q == ST_RUN && sts.cnt_last, state_q == ST_DECIDE)
	`MEXP_ASSERT_NXT(a_emit_shows_result, clk, arst_n, cmd.emit, out_valid)
	`MEXP_ASSERT_NXT(a_done_holds, clk, arst_n, state_q == ST_DONE && out_valid && !out_ready, state_q == ST_DONE)

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import mexp_pkg::*;

	localparam int W = DEFAULT_WORD_BITS;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int TAIL_CYCLES = 4 * (W + 1);
	localparam int RANDOM_PHASES = 14;
	localparam int WORDS_PER_PHASE = 20;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = CFG_INDEX_BITS'(3);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [W-1:0] cipher_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [W-1:0] plain_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [W-1:0] cfg_data = '0;

	logic [W-1:0] key_mod = W'(1);
	logic [W-1:0] key_exp = '0;
	logic [W-1:0] pending_words[$];
	logic [W-1:0] plain_expected[$];
	logic [W-1:0] want_word;
	logic word_taken = 1'b0;
	int failures = 0;
	int unsigned cycle_count = 0;

	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned max_gap = 3;
	int unsigned ready_pct = 80;
	int unsigned max_hold = 8;
	int unsigned hold_left = 0;

	modular_exponentiation_unit #(
		.WORD_BITS(W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cipher_word(cipher_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.plain_word(plain_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// square-and-multiply from the low exponent bit, products kept at double width
	function automatic logic [W-1:0] mod_power(input logic [W-1:0] base,
			input logic [W-1:0] exponent, input logic [W-1:0] modulus);
		logic [2*W-1:0] acc;
		logic [2*W-1:0] sq;
		logic [2*W-1:0] m;
		logic [W-1:0] e;
		if (exponent == '0)
			return W'(1);
		if (modulus == '0)
			return '0;
		m = {{W{1'b0}}, modulus};
		acc = (2*W)'(1) % m;
		sq = {{W{1'b0}}, base} % m;
		e = exponent;
		while (e != '0) begin
			if (e[0])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
			e = e >> 1;
		end
		return acc[W-1:0];
	endfunction

	function automatic logic [W-1:0] pick_modulus();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return W'(1);
			2: return W'($urandom_range(2, 255));
			3: return W'($urandom_range(256, 65535));
			4: return ($urandom_range(0, 3) == 0) ? '0 : W'($urandom);
			default: return W'($urandom) | W'(1);
		endcase
	endfunction

	function automatic logic [W-1:0] pick_exponent();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return W'($urandom_range(1, 3));
			default: return W'($urandom) >> $urandom_range(0, W - 1);
		endcase
	endfunction

	function automatic logic [W-1:0] pick_word(input logic [W-1:0] modulus);
		case ($urandom_range(0, 9))
			0: return modulus;
			1: return modulus - W'(1);
			2: return W'($urandom_range(0, 3));
			3: return '1;
			4: return modulus + W'($urandom_range(1, 16));
			default: return W'($urandom);
		endcase
	endfunction

	// queue one word for the input driver
	task automatic send_word(input logic [W-1:0] value);
		pending_words = {pending_words, value};
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || in_valid || plain_expected.size() != 0);
	endtask

	// input driver, bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_taken) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_valid <= 1'b1;
				cipher_word <= pending_words.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, stalls in runs
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(0, 99) < ready_pct);
			hold_left = $urandom_range(0, max_hold);
		end
	end

	// monitor: key registers, predictions and result checks
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("modular_exponentiation_unit test failed");
			$finish;
		end
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_MODULUS: key_mod = cfg_data;
					REG_KEY_EXPONENT: key_exp = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				plain_expected = {plain_expected, mod_power(cipher_word, key_exp, key_mod)};
				word_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (plain_expected.size() == 0) begin
					$error("plain_word unexpected transfer: expected none, actual %h", plain_word);
					failures++;
				end else begin
					want_word = plain_expected.pop_front();
					if (plain_word !== want_word) begin
						$error("plain_word mismatch: expected %h, actual %h", want_word,
							plain_word);
						failures++;
					end
				end
			end
		end
	end

	initial begin
		logic [W-1:0] modulus;
		logic [W-1:0] exponent;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// key registers straight out of reset: zero exponent, modulus one
		send_word('0);
		send_word('1);
		wait_drained();

		// zero modulus
		cfg_write(REG_KEY_MODULUS, '0);
		send_word(W'(32'h1234));
		wait_drained();
		cfg_write(REG_KEY_EXPONENT, W'(5));
		send_word('0);
		send_word(W'(7));
		wait_drained();

		// all ones key, longest exponent
		cfg_write(REG_KEY_MODULUS, '1);
		cfg_write(REG_KEY_EXPONENT, '1);
		send_word('0);
		send_word(W'(1));
		send_word('1 - W'(1));
		send_word('1);
		send_word(W'(32'h1234_5678));
		wait_drained();

		cfg_write(REG_KEY_MODULUS, W'(1));
		cfg_write(REG_KEY_EXPONENT, W'(3));
		send_word(W'(5));
		send_word('1);
		wait_drained();

		// base above and below the modulus
		cfg_write(REG_KEY_MODULUS, W'(32'hFFFF_FFFB));
		cfg_write(REG_KEY_EXPONENT, W'(1));
		send_word('1);
		send_word(W'(32'h8000_0000));
		wait_drained();

		cfg_write(REG_KEY_EXPONENT, W'(32'h8000_0000));
		send_word(W'(3));
		send_word(W'(32'hFFFF_FFFA));
		wait_drained();

		// writes past the register list leave the key alone
		cfg_write(REG_SPARE_A, W'($urandom));
		cfg_write(REG_SPARE_B, '1);
		send_word(W'(2));
		send_word(W'(32'hDEAD_BEEF));
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			modulus = pick_modulus();
			exponent = pick_exponent();
			if ($urandom_range(0, 1)) begin
				cfg_write(REG_KEY_MODULUS, modulus);
				cfg_write(REG_KEY_EXPONENT, exponent);
			end else begin
				cfg_write(REG_KEY_EXPONENT, exponent);
				cfg_write(REG_KEY_MODULUS, modulus);
			end
			if ($urandom_range(0, 3) == 0)
				cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, W'($urandom));
			case (p % 3)
				0: begin
					ready_pct = 100;
					max_gap = 0;
				end
				1: begin
					ready_pct = 70;
					max_gap = 6;
				end
				default: begin
					ready_pct = 30;
					max_gap = 20;
				end
			endcase
			max_hold = $urandom_range(1, 40);
			for (int i = 0; i < WORDS_PER_PHASE; i++)
				send_word(pick_word(modulus));
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && plain_expected.size() == 0) begin
			$display("modular_exponentiation_unit test passed");
		end else begin
			$display("modular_exponentiation_unit test failed");
		end
		$finish;
	end

endmodule
